// File: rtl/dep_pkg.sv
// Shared types and constants for the distant element projection pipeline.
// Used by distant_element_projection_unit and its testbench; no other dependencies.
`default_nettype none
package dep_pkg;

  localparam int COORD_W  = 16;
  localparam int ROOT_W   = 8;
  localparam int NUM_W    = 23;
  localparam int SHIFT_W  = 24;
  localparam int SCALE_W  = 8;
  localparam int SQ_STG   = ROOT_W;
  localparam int DIV_STG  = NUM_W;
  localparam int FRONT_STG = 3;
  localparam int NSTG     = FRONT_STG + SQ_STG + DIV_STG;

  localparam logic [7:0] SHIFT_GAIN = 8'd210;
  localparam logic [7:0] FULL_SCALE = 8'h40;

  localparam logic [7:0] MODE_BACKDROP   = 8'd0;
  localparam logic [7:0] MODE_POSITIONED = 8'd1;

  localparam logic [7:0] CFG_MAP_OFFSET_X = 8'd0;
  localparam logic [7:0] CFG_MAP_OFFSET_Y = 8'd1;

  typedef struct packed {
    logic                      vis;
    logic                      act;
    logic                      neg;
    logic signed [COORD_W-1:0] f;
    logic signed [COORD_W-1:0] l;
    logic [COORD_W-1:0]        fade;
    logic [15:0]               ll;
    logic [15:0]               ff;
    logic [15:0]               s;
    logic [ROOT_W-1:0]         root;
    logic [NUM_W-1:0]          num;
    logic [ROOT_W-1:0]         rem;
    logic [NUM_W-1:0]          quo;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/distant_element_projection_unit.sv
// Structure: 34 pipeline stages plus an output register.
// Throughput: one beat per cycle; the whole pipe stalls together when a result is held and out_tready is low.
// Stages: front end (offsets, rotation), squares and gain product, sum, 8 square-root
// bit stages, 23 restoring-division bit stages.
// Reset (rst_n, synchronous): clears stage valid bits, output valid and both map offsets.
// Depends on dep_pkg.
`default_nettype none
module distant_element_projection_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // facing[1:0], viewer_x[11:2], viewer_y[21:12], anchor_x[37:22],
  // anchor_y[53:38], fade_distance[69:54], zero pad
  input  wire logic [71:0] in_tdata,
  // placement_mode[7:0]
  input  wire logic [7:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // screen_x_shift[23:0], draw_scale[31:24]
  output logic [31:0]      out_tdata,
  // visible[0]
  output logic             out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int NSTG = dep_pkg::NSTG;
  localparam int SQ0  = dep_pkg::FRONT_STG;
  localparam int DV0  = dep_pkg::FRONT_STG + dep_pkg::SQ_STG;

  logic [9:0] mox_r, moy_r;
  logic       advance;

  dep_pkg::stage_t st_r   [NSTG];
  dep_pkg::stage_t st_nxt [NSTG];
  logic [NSTG-1:0] vld_r;

  logic                             out_valid_r;
  logic [dep_pkg::SHIFT_W-1:0]      shift_r;
  logic [dep_pkg::SCALE_W-1:0]      scale_r;
  logic                             vis_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;
  assign cfg_ready = 1'b1;

  // map offsets; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mox_r <= '0;
      moy_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == dep_pkg::CFG_MAP_OFFSET_X) mox_r <= cfg_data;
      else if (cfg_index == dep_pkg::CFG_MAP_OFFSET_Y) moy_r <= cfg_data;
    end
  end

  // front end: viewer position, rotation into view space
  logic [15:0] px, py, ax, ay, fw, lt;
  logic [7:0]  mode;
  always_comb begin
    px   = {6'd0, in_tdata[11:2]} + {6'd0, mox_r};
    py   = {6'd0, in_tdata[21:12]} + {6'd0, moy_r};
    ax   = in_tdata[37:22];
    ay   = in_tdata[53:38];
    mode = in_tuser;
    case (in_tdata[1:0])
      2'd0:    begin fw = py - ay; lt = ax - px; end
      2'd1:    begin fw = ax - px; lt = ay - py; end
      2'd2:    begin fw = ay - py; lt = px - ax; end
      default: begin fw = px - ax; lt = py - ay; end
    endcase
  end

  always_comb begin
    logic [dep_pkg::ROOT_W-1:0] trial;
    logic [15:0]                sq;
    logic [dep_pkg::ROOT_W:0]   rem2;
    logic [dep_pkg::ROOT_W-1:0] dv;
    logic [15:0]                lmag;
    int                         k;
    trial = '0; sq = '0; rem2 = '0; dv = '0; lmag = '0; k = 0;

    st_nxt[0]      = '0;
    st_nxt[0].f    = $signed(fw);
    st_nxt[0].l    = $signed(lt);
    st_nxt[0].neg  = lt[15];
    st_nxt[0].fade = in_tdata[69:54];
    st_nxt[0].vis  = (mode == dep_pkg::MODE_BACKDROP) ||
                     ((mode == dep_pkg::MODE_POSITIONED) && !fw[15] && (fw != 16'd0));
    st_nxt[0].act  = (mode == dep_pkg::MODE_POSITIONED) && !fw[15] && (fw != 16'd0);

    for (int i = 1; i < NSTG; i++) begin
      st_nxt[i] = st_r[i-1];
      if (i == 1) begin
        // squares (low 16 bits only matter) and |l|*210
        sq = 16'(st_r[0].l * st_r[0].l);
        st_nxt[i].ll = sq;
        sq = 16'(st_r[0].f * st_r[0].f);
        st_nxt[i].ff = sq;
        lmag = st_r[0].neg ? 16'(-st_r[0].l) : 16'(st_r[0].l);
        st_nxt[i].num = dep_pkg::NUM_W'({7'd0, lmag} * {15'd0, dep_pkg::SHIFT_GAIN});
      end else if (i == 2) begin
        st_nxt[i].s    = st_r[1].ll + st_r[1].ff;
        st_nxt[i].root = '0;
      end else if (i < DV0) begin
        // one root bit per stage, msb first
        k     = dep_pkg::ROOT_W - 1 - (i - SQ0);
        trial = st_r[i-1].root | (dep_pkg::ROOT_W'(1) << k);
        sq    = {8'd0, trial} * {8'd0, trial};
        if (sq <= st_r[i-1].s) st_nxt[i].root = trial;
      end else begin
        // one quotient bit per stage, msb first
        k = dep_pkg::NUM_W - 1 - (i - DV0);
        if (i == DV0) begin
          dv = (st_r[i-1].root == '0) ? dep_pkg::ROOT_W'(1) : st_r[i-1].root;
          st_nxt[i].root = dv;
          rem2 = {8'd0, st_r[i-1].num[k]};
          st_nxt[i].quo = '0;
        end else begin
          dv   = st_r[i-1].root;
          rem2 = {st_r[i-1].rem, st_r[i-1].num[k]};
        end
        if (rem2 >= {1'b0, dv}) begin
          rem2 = rem2 - {1'b0, dv};
          st_nxt[i].quo[k] = 1'b1;
        end
        st_nxt[i].rem = rem2[dep_pkg::ROOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NSTG; i++) st_r[i] <= st_nxt[i];
    end
  end

  // output stage: sign restore and scale clamp
  logic signed [17:0]           scale_w;
  logic [dep_pkg::SHIFT_W-1:0]  shift_mag;
  logic [dep_pkg::SHIFT_W-1:0]  shift_nxt;
  logic [dep_pkg::SCALE_W-1:0]  scale_nxt;
  always_comb begin
    scale_w   = $signed({2'b00, st_r[NSTG-1].fade}) + 18'sd64
              - $signed({10'd0, st_r[NSTG-1].root});
    shift_mag = {1'b0, st_r[NSTG-1].quo};
    if (!st_r[NSTG-1].act) begin
      shift_nxt = '0;
      scale_nxt = dep_pkg::FULL_SCALE;
    end else begin
      shift_nxt = st_r[NSTG-1].neg ? -shift_mag : shift_mag;
      if (scale_w < 18'sd1)        scale_nxt = 8'd1;
      else if (scale_w > 18'sd255) scale_nxt = 8'd255;
      else                         scale_nxt = scale_w[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      shift_r <= shift_nxt;
      scale_r <= scale_nxt;
      vis_r   <= st_r[NSTG-1].vis;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {scale_r, shift_r};
  assign out_tuser  = vis_r;

endmodule
`default_nettype wire

// File: tb/distant_element_projection_unit_test.sv
// Self-checking bench for distant_element_projection_unit: directed and random element beats,
// predicted in-bench and compared against the result stream. Depends on dep_pkg and the RTL.
`default_nettype none
module distant_element_projection_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        vis;
    logic [23:0] shift;
    logic [7:0]  scale;
  } projection_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [7:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  distant_element_projection_unit u_dut (.*);

  // Local copies of the map offsets
  logic [9:0] offset_x_q, offset_y_q;
  projection_t pending_q[$];
  int    fail_count = 0;
  int    results_seen = 0;
  bit    quiet = 1'b0;   // no idling in the closing stretch
  longint cycle_count = 0;

  localparam int LATENCY = 35;
  localparam longint CYCLE_LIMIT = 400000;

  initial forever #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [15:0] newton_root(logic [15:0] s);
    logic [15:0] c, prev;
    if (s <= 16'd2) return 16'd1;
    c = s >> 1;
    do begin
      prev = c;
      if (c == 0) break;
      c = 16'((32'(c) + 32'(s) / 32'(c)) >> 1);
    end while (c < prev);
    return prev;
  endfunction

  function automatic projection_t project(logic [1:0] facing, logic [9:0] vx, logic [9:0] vy,
                                          logic [7:0] mode, logic [15:0] ax, logic [15:0] ay,
                                          logic [15:0] fade);
    projection_t r;
    logic [15:0] px, py, fw, lt, s, d;
    int f, l, shift, scale;
    r = '{vis: 1'b0, shift: 24'd0, scale: dep_pkg::FULL_SCALE};
    if (mode == dep_pkg::MODE_BACKDROP) begin
      r.vis = 1'b1;
      return r;
    end
    if (mode != dep_pkg::MODE_POSITIONED) return r;
    px = 16'(vx) + 16'(offset_x_q);
    py = 16'(vy) + 16'(offset_y_q);
    case (facing)
      2'd0: begin fw = py - ay; lt = ax - px; end
      2'd1: begin fw = ax - px; lt = ay - py; end
      2'd2: begin fw = ay - py; lt = px - ax; end
      default: begin fw = px - ax; lt = py - ay; end
    endcase
    f = int'($signed(fw));
    l = int'($signed(lt));
    if (f < 1) return r;
    s = 16'(l * l + f * f);
    d = newton_root(s);
    if (d == 0) d = 16'd1;
    shift = (l * 210) / int'(d);
    scale = 64 - int'(d) + int'(fade);
    if (scale < 1) scale = 1;
    if (scale > 255) scale = 255;
    r.vis = 1'b1;
    r.shift = 24'(shift);
    r.scale = 8'(scale);
    return r;
  endfunction

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Send one element beat and queue its prediction on acceptance
  task automatic send_element(logic [1:0] facing, logic [9:0] vx, logic [9:0] vy,
                              logic [7:0] mode, logic [15:0] ax, logic [15:0] ay,
                              logic [15:0] fade);
    idle_gap();
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, fade, ay, ax, vy, vx, facing};
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(project(facing, vx, vy, mode, ax, ay, fade));
  endtask

  task automatic write_offset(logic [7:0] idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == dep_pkg::CFG_MAP_OFFSET_X) offset_x_q = val;
    else if (idx == dep_pkg::CFG_MAP_OFFSET_Y) offset_y_q = val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Result sink with random back-pressure bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      projection_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat");
        fail_count++;
      end else begin
        exp_r = pending_q.pop_front();
        results_seen++;
        if (out_tuser !== exp_r.vis) begin
          $error("visible: expected %0d, got %0d", exp_r.vis, out_tuser);
          fail_count++;
        end
        if (out_tdata[23:0] !== exp_r.shift) begin
          $error("screen_x_shift: expected %0d, got %0d",
                 $signed(exp_r.shift), $signed(out_tdata[23:0]));
          fail_count++;
        end
        if (out_tdata[31:24] !== exp_r.scale) begin
          $error("draw_scale: expected %0d, got %0d", exp_r.scale, out_tdata[31:24]);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_element(2'd0, 10'd0, 10'd0, dep_pkg::MODE_BACKDROP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_element(2'd3, 10'd1023, 10'd1023, 8'd2, 16'd0, 16'd0, 16'd0);
    send_element(2'd1, 10'd5, 10'd5, 8'd255, 16'd9, 16'd9, 16'd9);
    // Each facing with an element ahead; facings 0 and 1 also with one not ahead
    send_element(2'd0, 10'd10, 10'd20, dep_pkg::MODE_POSITIONED, 16'd13, 16'd10, 16'd0);
    send_element(2'd0, 10'd10, 10'd20, dep_pkg::MODE_POSITIONED, 16'd13, 16'd30, 16'd0);
    send_element(2'd1, 10'd10, 10'd20, dep_pkg::MODE_POSITIONED, 16'd40, 16'd15, 16'd100);
    send_element(2'd1, 10'd10, 10'd20, dep_pkg::MODE_POSITIONED, 16'd10, 16'd15, 16'd100);
    send_element(2'd2, 10'd10, 10'd20, dep_pkg::MODE_POSITIONED, 16'd7, 16'd25, 16'd300);
    send_element(2'd3, 10'd10, 10'd20, dep_pkg::MODE_POSITIONED, 16'd3, 16'd29, 16'd0);
    // Tiny sums: distance 1
    send_element(2'd0, 10'd0, 10'd1, dep_pkg::MODE_POSITIONED, 16'd0, 16'd0, 16'd0);
    send_element(2'd0, 10'd0, 10'd1, dep_pkg::MODE_POSITIONED, 16'd1, 16'd0, 16'd0);
    // Wrap-around and extremes
    send_element(2'd0, 10'd1023, 10'd1023, dep_pkg::MODE_POSITIONED,
                 16'hFFFF, 16'h8000, 16'hFFFF);
    send_element(2'd3, 10'd0, 10'd0, dep_pkg::MODE_POSITIONED, 16'h8001, 16'h7FFF, 16'd0);
    send_element(2'd1, 10'd0, 10'd0, dep_pkg::MODE_POSITIONED, 16'h7FFF, 16'h8000, 16'd0);
    send_element(2'd2, 10'd1023, 10'd0, dep_pkg::MODE_POSITIONED, 16'd300, 16'h0100, 16'd0);
    drain();
  endtask

  task automatic test_random(int count);
    logic [7:0] mode;
    logic [15:0] ax, ay;
    logic [9:0] vx, vy;
    for (int i = 0; i < count; i++) begin
      vx = 10'($urandom);
      vy = 10'($urandom);
      case ($urandom_range(0, 9))
        0: mode = dep_pkg::MODE_BACKDROP;
        1: mode = 8'($urandom_range(2, 255));
        default: mode = dep_pkg::MODE_POSITIONED;
      endcase
      // Mostly nearby elements so distances and scales vary usefully
      if ($urandom_range(0, 3) == 0) begin
        ax = 16'($urandom);
        ay = 16'($urandom);
      end else begin
        ax = 16'(vx) + 16'(offset_x_q) + 16'($urandom_range(0, 400)) - 16'd200;
        ay = 16'(vy) + 16'(offset_y_q) + 16'($urandom_range(0, 400)) - 16'd200;
      end
      send_element(2'($urandom), vx, vy, mode, ax, ay,
                   $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom));
    end
  endtask

  task automatic test_offsets();
    logic [9:0] settings[4][2] = '{'{10'd0, 10'd0}, '{10'd1023, 10'd1023},
                                   '{10'd517, 10'd3}, '{10'd0, 10'd1023}};
    foreach (settings[k]) begin
      write_offset(dep_pkg::CFG_MAP_OFFSET_X, settings[k][0]);
      write_offset(dep_pkg::CFG_MAP_OFFSET_Y, settings[k][1]);
      write_offset(8'd2 + 8'($urandom_range(0, 250)), 10'($urandom));  // ignored index
      if (k == 3) quiet = 1'b1;
      test_random(k == 3 ? 150 : 150);
      drain();
    end
    write_offset(dep_pkg::CFG_MAP_OFFSET_X, 10'($urandom));
    write_offset(dep_pkg::CFG_MAP_OFFSET_Y, 10'($urandom));
    test_random(120);
    drain();
  endtask

  initial begin
    offset_x_q = '0;
    offset_y_q = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_offsets();
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
